>>> rtl/ovl_pkg.sv
package ovl_pkg;

    // List size and the widths that follow from it
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LOG_W    = $clog2(CAPACITY);

    // Field widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 7;

    // Operation codes; any other code only reports
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic                      insert_en;
        logic                      delete_en;
        logic signed [VALUE_W-1:0] new_value;
    } cell_ctrl_t;

endpackage

>>> rtl/ordered_value_list.sv
// Ordered value list: keeps up to CAPACITY signed 32-bit entries in order and
// performs one operation per command: insert before the first entry equal to
// key (append when none matches), delete the first entry equal to key, or find.
//
// Command channel: op, key and new_value are taken at a rising edge with start
// high and busy low. Busy is then high for one cycle while the cell row shifts.
// Result channel: found, position, length and rejected are shown for exactly
// one cycle with done high, the cycle after the busy cycle. The receiver
// cannot stall the block; a result is lost if it is not taken in that cycle.
//
// The command edge registers a compare in every cell; the busy cycle then
// resolves the first match across the row and moves each cell's entry from
// its neighbour. No command is taken while busy is high; a new command may
// be given in the cycle in which done is high.
//
// Reset clears the length to zero and drops any command in flight; entry
// contents are not cleared and are never read beyond the current length.
// Insert into a full list leaves it unchanged and flags rejected.
module ordered_value_list
    import ovl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           op,
    input  logic signed [VALUE_W-1:0] key,
    input  logic signed [VALUE_W-1:0] new_value,
    output logic                      done,
    output logic                      found,
    output logic [OUT_W-1:0]          position,
    output logic [OUT_W-1:0]          length,
    output logic                      rejected
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [OP_W-1:0]           op_reg;
    logic signed [VALUE_W-1:0] new_value_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      found_reg;
    logic [OUT_W-1:0]          position_reg;
    logic [OUT_W-1:0]          length_reg;
    logic                      rejected_reg;

    logic                      capture;
    logic                      full;
    logic                      hit;
    logic [CNT_W-1:0]          pos;
    logic [CAPACITY-1:0]       match;
    logic [CAPACITY-1:0]       ge;
    logic signed [VALUE_W-1:0] values [0:CAPACITY-1];
    cell_ctrl_t                ctrl;

    assign capture = start && !busy_reg;
    assign full    = count_reg == CNT_W'(CAPACITY);

    // Broadcast the shift command during the busy cycle
    assign ctrl.insert_en = busy_reg && (op_reg == OP_INSERT) && !full;
    assign ctrl.delete_en = busy_reg && (op_reg == OP_DELETE) && hit;
    assign ctrl.new_value = new_value_reg;

    // Row of cells, each fed by its neighbours
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic signed [VALUE_W-1:0] right_value;
        logic                      ge_left;

        if (i == 0)
        begin : g_head
            assign left_value = '0;
            assign ge_left    = 1'b0;
        end
        else
        begin : g_body
            assign left_value = values[i-1];
            assign ge_left    = ge[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = values[i];
        end
        else
        begin : g_inner
            assign right_value = values[i+1];
        end

        ovl_cell u_cell (
            .clk         (clk),
            .capture     (capture),
            .idx         (CNT_W'(i)),
            .count       (count_reg),
            .key         (key),
            .ge_self     (ge[i]),
            .ge_left     (ge_left),
            .left_value  (left_value),
            .right_value (right_value),
            .ctrl        (ctrl),
            .value       (values[i]),
            .match       (match[i])
        );
    end

    // Resolve the first match over the row
    ovl_prefix u_prefix (
        .match (match),
        .count (count_reg),
        .ge    (ge),
        .hit   (hit),
        .pos   (pos)
    );

    // Advance the length
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_en)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.delete_en)
            count_next = count_reg - CNT_W'(1);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= capture;
            done_reg  <= busy_reg;
            count_reg <= count_next;
        end
    end

    // Hold the command and register the result
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_reg        <= op;
            new_value_reg <= new_value;
        end
        if (busy_reg)
        begin
            found_reg    <= hit;
            position_reg <= OUT_W'(pos);
            length_reg   <= OUT_W'(count_next);
            rejected_reg <= (op_reg == OP_INSERT) && full;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;
    assign length   = length_reg;
    assign rejected = rejected_reg;

endmodule

>>> rtl/ovl_cell.sv
module ovl_cell
    import ovl_pkg::*;
(
    input  logic                      clk,
    input  logic                      capture,
    input  logic [CNT_W-1:0]          idx,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [VALUE_W-1:0] key,
    input  logic                      ge_self,
    input  logic                      ge_left,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic signed [VALUE_W-1:0] right_value,
    input  cell_ctrl_t                ctrl,
    output logic signed [VALUE_W-1:0] value,
    output logic                      match
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      match_reg;
    logic                      match_next;

    // Compare the stored entry against the key as the transfer is taken
    assign match_next = (value_reg == key) && (idx < count);

    // Take the new value, the left neighbour's or the right neighbour's, or hold
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (ge_self && !ge_left)
                value_next = ctrl.new_value;
            else if (ge_left)
                value_next = left_value;
        end
        else if (ctrl.delete_en && ge_self)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (capture)
            match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

>>> rtl/ovl_prefix.sv
module ovl_prefix
    import ovl_pkg::*;
(
    input  logic [CAPACITY-1:0] match,
    input  logic [CNT_W-1:0]    count,
    output logic [CAPACITY-1:0] ge,
    output logic                hit,
    output logic [CNT_W-1:0]    pos
);

    logic [CAPACITY-1:0] lvl [0:LOG_W];
    logic [CAPACITY-1:0] first;
    logic [CAPACITY-1:0] active;
    logic [IDX_W-1:0]    enc;

    // Spread each match towards the tail in log steps
    always_comb
    begin
        lvl[0] = match;
        for (int l = 0; l < LOG_W; l++)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (i >= (1 << l))
                    lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
                else
                    lvl[l+1][i] = lvl[l][i];
            end
        end
    end

    // Mark the first match, the occupied cells and the cells at or past the position
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
                first[i] = match[i];
            else
                first[i] = match[i] & ~lvl[LOG_W][i-1];
            active[i] = CNT_W'(i) < count;
            ge[i]     = lvl[LOG_W][i] | ~active[i];
        end
    end

    // Encode the one-hot first match
    always_comb
    begin
        enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first[i])
                enc = enc | IDX_W'(i);
        end
    end

    assign hit = |match;
    assign pos = hit ? CNT_W'(enc) : count;

endmodule

>>> rtl/ovl_checker.sv
module ovl_checker
    import ovl_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      done,
    input logic [OUT_W-1:0]          length,
    input logic                      rejected
);

    // A taken command makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer did not raise busy");

    // The busy cycle is followed by exactly one result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("no result after busy cycle");

    // A result only follows a busy cycle
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command");

    // A refused insert reports a full list
    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && rejected |-> length == OUT_W'(CAPACITY))
        else $error("rejected insert on a list that is not full");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (.*);
